/* sv/assert_macros.svh */
// Assertion macros for the checker file of the frame table.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is low
`define CFT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("frame table check failed");

// clocked assertion that also holds during reset
`define CFT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("frame table check failed");

`endif

/* sv/cft_pkg.sv */
// Package for the clock frame table: field widths, command and status codes,
// controller states and the cell entry / token types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cft_pkg;

  localparam int unsigned FRAMES_DEF = 64;
  localparam int unsigned KEY_W      = 20;
  localparam int unsigned OWNER_W    = 16;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned S_DATA_W   = 40;
  localparam int unsigned M_DATA_W   = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_MARK   = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_VICTIM = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  // contents of one table position
  typedef struct packed {
    logic               occ;
    logic               used;
    logic               hand;
    logic [KEY_W-1:0]   key;
    logic [OWNER_W-1:0] owner;
  } ent_t;

  // command wave that walks the row one cell per cycle
  typedef struct packed {
    logic               vld;
    cmd_e               op;
    logic               pass;
    logic               armed;
    logic               found;
    logic               wrap;
    logic [KEY_W-1:0]   key;
    logic [OWNER_W-1:0] owner;
  } tok_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tbl_stat_t;

endpackage

`default_nettype wire

/* sv/clock_frame_table_core.sv */
// Clock frame table: a packed, insertion-ordered table of FRAMES resident
// frames with second-chance victim choice, built as a row of cells that a
// command wave walks one cell per clock. One word is in flight at a time; its
// result comes from the wave crossing the row, then goes through the result
// register into the output register; a victim search that must wrap makes a
// second lap, and a full add or an empty victim search launches no wave. The
// input is taken again once the result has moved into the output register;
// a result still waiting there when the next wave is done holds that wave and
// the input. Depends on cft_pkg, cft_ctrl and cft_cell.
`timescale 1ns / 1ps
`default_nettype none

module clock_frame_table_core import cft_pkg::*; #(
  parameter int unsigned FRAMES = FRAMES_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [1:0] cmd, [21:2] frame_page, [37:22] owner_id, [39:38] zero
  input  wire  [S_DATA_W-1:0] s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  wire                 m_axis_tready_i,
  // [1:0] status, [21:2] victim_frame, [37:22] victim_owner, [39:38] zero
  output logic [M_DATA_W-1:0] m_axis_tdata_o
);

  tok_t      tok [FRAMES+1];
  ent_t      ent [FRAMES];
  tbl_stat_t stat;
  logic      hand_set;

  assign stat.full  = ent[FRAMES-1].occ;
  assign stat.empty = ~ent[0].occ;

  cft_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .inj_o           (tok[0]),
    .exit_i          (tok[FRAMES]),
    .stat_i          (stat),
    .hand_set_o      (hand_set)
  );

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    ent_t nb;
    logic hs;
    if (i == FRAMES - 1) begin : g_last
      assign nb = '0;
    end else begin : g_mid
      assign nb = ent[i+1];
    end
    if (i == 0) begin : g_first
      assign hs = hand_set;
    end else begin : g_rest
      assign hs = 1'b0;
    end
    cft_cell #(
      .HandInit (i == 0)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .hand_set_i (hs),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1]),
      .nb_i       (nb),
      .ent_o      (ent[i])
    );
  end

endmodule

`default_nettype wire

/* sv/cft_cell.sv */
// One table position of the frame table row: holds an entry and the command
// wave register that hands the wave to the next cell. Depends on cft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cft_cell import cft_pkg::*; #(
  parameter bit HandInit = 1'b0
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  hand_set_i,
  input  tok_t tok_i,
  output tok_t tok_o,
  input  ent_t nb_i,
  output ent_t ent_o
);

  ent_t ent_q, ent_d;
  tok_t tok_q, tok_d;
  logic hit;
  logic arm;
  logic act;

  always_comb begin
    ent_d = ent_q;
    tok_d = tok_i;
    hit   = 1'b0;
    arm   = 1'b0;
    act   = 1'b0;
    if (tok_i.vld) begin
      case (tok_i.op)
        CMD_ADD: begin
          if (!ent_q.occ && !tok_i.found) begin
            ent_d.occ   = 1'b1;
            ent_d.used  = 1'b1;
            ent_d.key   = tok_i.key;
            ent_d.owner = tok_i.owner;
            tok_d.found = 1'b1;
          end
        end
        CMD_MARK: begin
          if (ent_q.occ && !tok_i.found && ent_q.key == tok_i.key) begin
            ent_d.used  = 1'b1;
            tok_d.found = 1'b1;
          end
        end
        CMD_FREE: begin
          hit = ent_q.occ && !tok_i.found && ent_q.key == tok_i.key;
          if (hit || tok_i.found) begin
            // close the gap: take the right neighbor's entry
            ent_d.occ   = nb_i.occ;
            ent_d.used  = nb_i.used;
            ent_d.key   = nb_i.key;
            ent_d.owner = nb_i.owner;
            ent_d.hand  = nb_i.hand | (hit & ent_q.hand & nb_i.occ);
          end
          if (hit) begin
            tok_d.found = 1'b1;
            tok_d.wrap  = ent_q.hand & ~nb_i.occ;
          end
        end
        CMD_VICTIM: begin
          arm         = tok_i.armed | ent_q.hand;
          act         = ent_q.occ && !tok_i.found && (tok_i.pass || arm);
          tok_d.armed = arm;
          ent_d.hand  = 1'b0;
          if (act) begin
            if (ent_q.used) begin
              ent_d.used = 1'b0;
            end else begin
              ent_d.hand  = 1'b1;
              tok_d.found = 1'b1;
              tok_d.key   = ent_q.key;
              tok_d.owner = ent_q.owner;
            end
          end
        end
        default: begin
          ent_d = ent_q;
        end
      endcase
    end
    if (hand_set_i) begin
      ent_d.hand = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '{occ: 1'b0, used: 1'b0, hand: HandInit, key: '0, owner: '0};
      tok_q <= '0;
    end else begin
      ent_q <= ent_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign ent_o = ent_q;

endmodule

`default_nettype wire

/* sv/cft_ctrl.sv */
// Sequencer of the frame table: takes input words, launches the command wave
// into the cell row, collects it at the end and drives the result register.
// Depends on cft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cft_ctrl import cft_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  wire  [S_DATA_W-1:0] s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  wire                 m_axis_tready_i,
  output logic [M_DATA_W-1:0] m_axis_tdata_o,
  output tok_t                inj_o,
  input  tok_t                exit_i,
  input  tbl_stat_t           stat_i,
  output logic                hand_set_o
);

  state_e state_q, state_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [KEY_W-1:0]    res_key_q, res_key_d;
  logic [OWNER_W-1:0]  res_owner_q, res_owner_d;
  logic                m_vld_q, m_vld_d;
  logic [M_DATA_W-1:0] m_data_q, m_data_d;
  cmd_e                in_cmd;

  assign in_cmd          = cmd_e'(s_axis_tdata_i[CMD_W-1:0]);
  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d         = state_q;
    res_status_d    = res_status_q;
    res_key_d       = res_key_q;
    res_owner_d     = res_owner_q;
    m_vld_d         = m_vld_q;
    m_data_d        = m_data_q;
    inj_o           = '0;
    hand_set_o      = 1'b0;
    if (m_vld_q && m_axis_tready_i) begin
      m_vld_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          res_key_d   = '0;
          res_owner_d = '0;
          if (in_cmd == CMD_ADD && stat_i.full) begin
            res_status_d = STATUS_FULL;
            state_d      = ST_DONE;
          end else if (in_cmd == CMD_VICTIM && stat_i.empty) begin
            res_status_d = STATUS_EMPTY;
            state_d      = ST_DONE;
          end else begin
            inj_o.vld   = 1'b1;
            inj_o.op    = in_cmd;
            inj_o.key   = s_axis_tdata_i[CMD_W +: KEY_W];
            inj_o.owner = s_axis_tdata_i[CMD_W+KEY_W +: OWNER_W];
            state_d     = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (exit_i.vld) begin
          if (exit_i.op == CMD_VICTIM && !exit_i.found && !exit_i.pass) begin
            // second lap from position zero
            inj_o       = exit_i;
            inj_o.pass  = 1'b1;
            inj_o.armed = 1'b0;
          end else begin
            hand_set_o   = exit_i.wrap;
            res_status_d = exit_i.found ? STATUS_OK : STATUS_NOT_FOUND;
            if (exit_i.op == CMD_VICTIM) begin
              res_key_d   = exit_i.key;
              res_owner_d = exit_i.owner;
            end
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!m_vld_q || m_axis_tready_i) begin
          m_vld_d  = 1'b1;
          m_data_d = {{(M_DATA_W-STATUS_W-KEY_W-OWNER_W){1'b0}},
                      res_owner_q, res_key_q, res_status_q};
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      m_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      m_vld_q <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_owner_q  <= res_owner_d;
    m_data_q     <= m_data_d;
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

`default_nettype wire

/* sv/cft_checker.sv */
// Port-level checks for clock_frame_table_core, bound to every instance.
// Depends on cft_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cft_checker import cft_pkg::*; (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                s_axis_tvalid_i,
  input wire                s_axis_tready_o,
  input wire [S_DATA_W-1:0] s_axis_tdata_i,
  input wire                m_axis_tvalid_o,
  input wire                m_axis_tready_i,
  input wire [M_DATA_W-1:0] m_axis_tdata_o
);

  `CFT_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
  `CFT_ASSERT(a_err_no_victim, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[STATUS_W-1:0] != STATUS_OK |-> m_axis_tdata_o[M_DATA_W-1:STATUS_W] == '0)
  `CFT_ASSERT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
  `CFT_ASSERT(a_no_instant_result, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> !$rose(m_axis_tvalid_o))
  `CFT_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !m_axis_tvalid_o)

endmodule

bind clock_frame_table_core cft_checker u_cft_checker (.*);

`default_nettype wire

/* dv/tb_clock_frame_table_core.sv */
// Testbench for clock_frame_table_core: streams add/mark/free/victim words, predicts
// each reply with a second-chance table model and checks replies in order.
// Depends on cft_pkg and the clock_frame_table_core RTL.
`timescale 1ns / 1ps

module tb_clock_frame_table_core;
  import cft_pkg::*;

  localparam int FRAMES = FRAMES_DEF;
  // worst case per word: a wrapping walk, the longest sender gap and the longest
  // receiver stall, over ~1725 words; allow several times that total
  localparam int CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    cmd_e               op;
    logic [KEY_W-1:0]   key;
    logic [OWNER_W-1:0] owner;
    logic               drain;
  } frame_req_t;

  typedef struct packed {
    status_e            status;
    logic [KEY_W-1:0]   frame;
    logic [OWNER_W-1:0] owner;
  } frame_reply_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;

  frame_req_t   req_q[$];
  frame_reply_t reply_q[$];
  frame_req_t   cur_req;
  int           send_gap;
  int           stall_left;
  int           errors;
  int           cycle_cnt;
  bit           quiet_run;

  // table shadow used for prediction
  logic [KEY_W-1:0]   tab_key[FRAMES];
  logic [OWNER_W-1:0] tab_owner[FRAMES];
  bit                 tab_used[FRAMES];
  int                 tab_count;
  int                 tab_hand;

  // key membership shadow used only to steer the generator
  logic [KEY_W-1:0]   live_keys[$];

  clock_frame_table_core #(.FRAMES(FRAMES)) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic frame_reply_t frame_table_apply(cmd_e op, logic [KEY_W-1:0] key,
                                                     logic [OWNER_W-1:0] owner);
    frame_reply_t rep;
    int           pos;
    int           steps;
    rep = '{status: STATUS_OK, frame: '0, owner: '0};
    pos = -1;
    for (int i = 0; i < tab_count; i++) begin
      if (pos < 0 && tab_key[i] == key) pos = i;
    end
    case (op)
      CMD_ADD: begin
        if (tab_count >= FRAMES) begin
          rep.status = STATUS_FULL;
        end else begin
          tab_key[tab_count]   = key;
          tab_owner[tab_count] = owner;
          tab_used[tab_count]  = 1'b1;
          tab_count++;
        end
      end
      CMD_MARK: begin
        if (pos < 0) rep.status = STATUS_NOT_FOUND;
        else tab_used[pos] = 1'b1;
      end
      CMD_FREE: begin
        if (pos < 0) begin
          rep.status = STATUS_NOT_FOUND;
        end else begin
          for (int i = pos; i + 1 < tab_count; i++) begin
            tab_key[i]   = tab_key[i+1];
            tab_owner[i] = tab_owner[i+1];
            tab_used[i]  = tab_used[i+1];
          end
          tab_count--;
          if (pos < tab_hand) tab_hand--;
          if (tab_hand >= tab_count) tab_hand = 0;
        end
      end
      default: begin
        if (tab_count == 0) begin
          rep.status = STATUS_EMPTY;
        end else begin
          if (tab_hand >= tab_count) tab_hand = 0;
          steps = 0;
          while (steps < 2 * FRAMES + 1 && tab_used[tab_hand]) begin
            tab_used[tab_hand] = 1'b0;
            tab_hand++;
            if (tab_hand >= tab_count) tab_hand = 0;
            steps++;
          end
          rep.frame = tab_key[tab_hand];
          rep.owner = tab_owner[tab_hand];
        end
      end
    endcase
    return rep;
  endfunction

  // mostly short idles, a few long ones, none during quiet stretches
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_run || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic queue_word(cmd_e op, logic [KEY_W-1:0] key, logic [OWNER_W-1:0] owner,
                            bit drain = 1'b0);
    int idx;
    req_q.push_back('{op: op, key: key, owner: owner, drain: drain});
    idx = -1;
    foreach (live_keys[i]) begin
      if (idx < 0 && live_keys[i] == key) idx = i;
    end
    if (op == CMD_ADD && live_keys.size() < FRAMES) live_keys.push_back(key);
    if (op == CMD_FREE && idx >= 0) live_keys.delete(idx);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(int hit_pct);
    if (live_keys.size() > 0 && $urandom_range(0, 99) < hit_pct)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    return KEY_W'($urandom());
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic                fire;
    logic [S_DATA_W-1:0] w;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      send_gap = 0;
    end else begin
      fire = s_tvalid && s_tready;
      if (fire) begin
        reply_q.push_back(frame_table_apply(cur_req.op, cur_req.key, cur_req.owner));
        send_gap = idle_len();
        if ($urandom_range(0, 99) == 0) quiet_run = !quiet_run;
      end
      if (!s_tvalid || fire) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (req_q.size() > 0 && (!req_q[0].drain || reply_q.size() == 0)) begin
          cur_req = req_q.pop_front();
          w = '0;
          w[CMD_W-1:0]             = cur_req.op;
          w[CMD_W +: KEY_W]        = cur_req.key;
          w[CMD_W+KEY_W +: OWNER_W] = cur_req.owner;
          s_tdata  <= w;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    frame_reply_t exp_r;
    logic [STATUS_W-1:0] got_status;
    logic [KEY_W-1:0]    got_frame;
    logic [OWNER_W-1:0]  got_owner;
    if (!rst_ni) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_status = m_tdata[STATUS_W-1:0];
        got_frame  = m_tdata[STATUS_W +: KEY_W];
        got_owner  = m_tdata[STATUS_W+KEY_W +: OWNER_W];
        if (reply_q.size() == 0) begin
          $display("%0t unexpected word: expected none, got %h", $time, m_tdata);
          errors++;
        end else begin
          exp_r = reply_q.pop_front();
          if (got_status != exp_r.status) begin
            $display("%0t status: expected %0d, got %0d", $time, exp_r.status, got_status);
            errors++;
          end
          if (got_frame != exp_r.frame) begin
            $display("%0t victim_frame: expected %h, got %h", $time, exp_r.frame, got_frame);
            errors++;
          end
          if (got_owner != exp_r.owner) begin
            $display("%0t victim_owner: expected %h, got %h", $time, exp_r.owner, got_owner);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 99) < 20) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int mode;
    int r;
    cmd_e op;
    rst_ni    = 1'b0;

    // directed: empty table, duplicates, extremes, hand moves on free
    queue_word(CMD_VICTIM, 20'h00000, 16'h0000);
    queue_word(CMD_MARK,   20'h00000, 16'hFFFF);
    queue_word(CMD_FREE,   20'hFFFFF, 16'h0000);
    queue_word(CMD_ADD,    20'h00000, 16'h0000);
    queue_word(CMD_ADD,    20'hFFFFF, 16'hFFFF);
    queue_word(CMD_ADD,    20'h00000, 16'h1234);
    queue_word(CMD_MARK,   20'hFFFFF, 16'h0000);
    queue_word(CMD_MARK,   20'h5A5A5, 16'h0000);
    queue_word(CMD_VICTIM, 20'h00000, 16'h0000);
    queue_word(CMD_VICTIM, 20'hFFFFF, 16'hFFFF);
    queue_word(CMD_MARK,   20'h00000, 16'h0000);
    queue_word(CMD_VICTIM, 20'h00000, 16'h0000);
    queue_word(CMD_FREE,   20'h00000, 16'h0000, 1'b1);
    queue_word(CMD_FREE,   20'hFFFFF, 16'h0000);
    queue_word(CMD_VICTIM, 20'h00000, 16'h0000);
    queue_word(CMD_FREE,   20'h00000, 16'h0000);
    queue_word(CMD_VICTIM, 20'h00000, 16'h0000);
    queue_word(CMD_FREE,   20'h00000, 16'h0000);
    queue_word(CMD_ADD,    20'hABCDE, 16'h8001);
    queue_word(CMD_ADD,    20'h12345, 16'h7FFE);
    queue_word(CMD_VICTIM, 20'h00000, 16'h0000);
    queue_word(CMD_FREE,   20'h12345, 16'h0000);

    // random: alternate fill, drain and mixed phases so the table hits full and empty
    mode = 0;
    for (int n = 0; n < 1700; n++) begin
      if (n % 150 == 0) mode = (n == 0) ? 0 : $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      case (mode)
        0:       op = (r < 60) ? CMD_ADD : (r < 70) ? CMD_MARK : (r < 80) ? CMD_FREE : CMD_VICTIM;
        1:       op = (r < 15) ? CMD_ADD : (r < 25) ? CMD_MARK : (r < 70) ? CMD_FREE : CMD_VICTIM;
        default: op = (r < 30) ? CMD_ADD : (r < 50) ? CMD_MARK : (r < 75) ? CMD_FREE : CMD_VICTIM;
      endcase
      if (op == CMD_ADD)
        queue_word(op, pick_key(25), OWNER_W'($urandom()), (n % 250) == 125);
      else
        queue_word(op, pick_key(85), OWNER_W'($urandom()), (n % 250) == 125);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || s_tvalid || reply_q.size() != 0) @(posedge clk_i);
    repeat (2 * FRAMES + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
